// ===== rtl/core/etnqn_pkg.sv =====
`timescale 1ns / 1ps
package etnqn_pkg;
    localparam int FRAC_BITS_DEF = 30;
    localparam int COMP_W        = 32;
    localparam int NUM_COMP      = 4;
endpackage

// ===== rtl/core/enu_to_ned_quaternion_normalize_core.sv =====
`timescale 1ns / 1ps
// channel   | dir | tdata (lsb up)                   | tuser
// ----------+-----+----------------------------------+-----------
// s_axis_*  | in  | in_x, in_y, in_z, in_w (32 each) | -
// m_axis_*  | out | out_x, out_y, out_z, out_w       | zero_norm
//
// One request per cycle while m_axis_tready does not stall the pipeline; the
// bit-per-stage normalizing quotient search has FRAC_BITS + 1 stages.
// aresetn is synchronous and active low; it clears the valid bits only and
// holds s_axis_tready low while asserted.
// A stalled result holds the whole pipeline; nothing is lost or repeated.
module enu_to_ned_quaternion_normalize_core #(
    parameter int FRAC_BITS = etnqn_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // in_x, in_y, in_z, in_w
    input  logic [4*etnqn_pkg::COMP_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_x, out_y, out_z, out_w
    output logic [4*etnqn_pkg::COMP_W-1:0]   m_axis_tdata,
    // zero_norm
    output logic                             m_axis_tuser
);
    import etnqn_pkg::*;

    localparam int NST = FRAC_BITS + 2;
    localparam int SW  = 65;
    localparam int NW  = 34;
    localparam int QW  = 65;
    localparam int DW  = 2 * FRAC_BITS + 70;
    localparam int MW  = FRAC_BITS + 1;

    logic ce;

    logic                     va_reg;
    logic signed [COMP_W-1:0] qa_reg [NUM_COMP];

    logic                     vb_reg;
    logic signed [NW-1:0]     nb_reg [NUM_COMP];
    logic [2*COMP_W-1:0]      sqb_reg [NUM_COMP];

    logic                     vc_reg;
    logic [SW-1:0]            sc_reg;
    logic                     zc_reg;
    logic [QW-1:0]            nsqc_reg [NUM_COMP];
    logic                     negc_reg [NUM_COMP];

    logic                     v_reg [NST];
    logic [SW-1:0]            s_reg [NST];
    logic                     z_reg [NST];
    logic signed [DW-1:0]     d_reg [NUM_COMP][NST];
    logic signed [DW-1:0]     p_reg [NUM_COMP][NST];
    logic [MW-1:0]            m_reg [NUM_COMP][NST];
    logic                     neg_reg [NUM_COMP][NST];

    logic signed [DW-1:0]     d_next [NUM_COMP][NST];
    logic signed [DW-1:0]     p_next [NUM_COMP][NST];
    logic [MW-1:0]            m_next [NUM_COMP][NST];

    logic                     vo_reg;
    logic [4*COMP_W-1:0]      o_reg;
    logic                     zo_reg;
    logic [4*COMP_W-1:0]      o_next;

    assign ce            = !vo_reg || m_axis_tready;
    assign s_axis_tready = ce && aresetn;
    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = o_reg;
    assign m_axis_tuser  = zo_reg;

    always_comb begin
        logic signed [DW-1:0] sx;
        logic signed [DW-1:0] delta;
        logic signed [DW-1:0] dn;
        logic                 allow;
        sx = $signed({{(DW-SW){1'b0}}, sc_reg});
        for (int j = 0; j < NUM_COMP; j++) begin
            d_next[j][0] = $signed({{(DW-QW){1'b0}}, nsqc_reg[j]}) <<< (2*FRAC_BITS + 1);
            d_next[j][0] = d_next[j][0] - sx;
            p_next[j][0] = -sx;
            m_next[j][0] = '0;
        end
        for (int k = 0; k <= FRAC_BITS; k++) begin
            sx = $signed({{(DW-SW){1'b0}}, s_reg[k]});
            for (int j = 0; j < NUM_COMP; j++) begin
                delta = (p_reg[j][k] <<< (FRAC_BITS - k + 2))
                      + (sx <<< (2*(FRAC_BITS - k) + 2));
                dn    = d_reg[j][k] - delta;
                allow = (k == 0) || !m_reg[j][k][FRAC_BITS];
                d_next[j][k+1] = d_reg[j][k];
                p_next[j][k+1] = p_reg[j][k];
                m_next[j][k+1] = m_reg[j][k];
                if (allow && !dn[DW-1]) begin
                    d_next[j][k+1] = dn;
                    p_next[j][k+1] = p_reg[j][k] + (sx <<< (FRAC_BITS - k + 1));
                    m_next[j][k+1] = m_reg[j][k] | (MW'(1) << (FRAC_BITS - k));
                end
            end
        end
    end

    always_comb begin
        logic [COMP_W-1:0] mag;
        for (int j = 0; j < NUM_COMP; j++) begin
            mag = COMP_W'(m_reg[j][NST-1]);
            if (z_reg[NST-1]) begin
                o_next[j*COMP_W +: COMP_W] = (j == NUM_COMP-1) ?
                                             (COMP_W'(1) << FRAC_BITS) : '0;
            end else if (neg_reg[j][NST-1]) begin
                o_next[j*COMP_W +: COMP_W] = -mag;
            end else begin
                o_next[j*COMP_W +: COMP_W] = mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k < NST; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            va_reg   <= s_axis_tvalid;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            v_reg[0] <= vc_reg;
            for (int k = 1; k < NST; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
            vo_reg <= v_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        logic [2*COMP_W+1:0] sum;
        logic [QW-1:0]       am;
        if (ce) begin
            for (int j = 0; j < NUM_COMP; j++) begin
                qa_reg[j] <= $signed(s_axis_tdata[j*COMP_W +: COMP_W]);
            end
            // x' w+z, y' w-z, z' y-x, w' -(x+y); the common sqrt(0.5) cancels
            nb_reg[0] <= NW'(qa_reg[3]) + NW'(qa_reg[2]);
            nb_reg[1] <= NW'(qa_reg[3]) - NW'(qa_reg[2]);
            nb_reg[2] <= NW'(qa_reg[1]) - NW'(qa_reg[0]);
            nb_reg[3] <= -(NW'(qa_reg[0]) + NW'(qa_reg[1]));
            for (int j = 0; j < NUM_COMP; j++) begin
                sqb_reg[j] <= $unsigned((2*COMP_W)'(qa_reg[j]) * (2*COMP_W)'(qa_reg[j]));
            end
            sum = (2*COMP_W+2)'(sqb_reg[0]) + (2*COMP_W+2)'(sqb_reg[1])
                + (2*COMP_W+2)'(sqb_reg[2]) + (2*COMP_W+2)'(sqb_reg[3]);
            sc_reg <= sum[SW-1:0];
            zc_reg <= (sum == '0);
            for (int j = 0; j < NUM_COMP; j++) begin
                am = nb_reg[j][NW-1] ? QW'($unsigned(-nb_reg[j])) : QW'($unsigned(nb_reg[j]));
                nsqc_reg[j] <= QW'(am[32:0] * am[32:0]);
                negc_reg[j] <= nb_reg[j][NW-1];
            end
            s_reg[0] <= sc_reg;
            z_reg[0] <= zc_reg;
            for (int k = 1; k < NST; k++) begin
                s_reg[k] <= s_reg[k-1];
                z_reg[k] <= z_reg[k-1];
            end
            for (int j = 0; j < NUM_COMP; j++) begin
                neg_reg[j][0] <= negc_reg[j];
                for (int k = 1; k < NST; k++) begin
                    neg_reg[j][k] <= neg_reg[j][k-1];
                end
                for (int k = 0; k < NST; k++) begin
                    d_reg[j][k] <= d_next[j][k];
                    p_reg[j][k] <= p_next[j][k];
                    m_reg[j][k] <= m_next[j][k];
                end
            end
            o_reg  <= o_next;
            zo_reg <= z_reg[NST-1];
        end
    end
endmodule

// ===== sim/tb_enu_to_ned_quaternion_normalize_core.sv =====
`timescale 1ns / 1ps
module tb_enu_to_ned_quaternion_normalize_core;
    import etnqn_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic [COMP_W-1:0] w;
        logic [COMP_W-1:0] z;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] x;
    } quat_t;

    typedef struct {
        logic [4*COMP_W-1:0] data;
        logic                zero_norm;
    } unit_quat_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [4*COMP_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [4*COMP_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    unit_quat_t pending_q[$];
    bit         failed = 1'b0;
    bit         calm = 1'b0;

    always #1 aclk = ~aclk;

    enu_to_ned_quaternion_normalize_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Largest m in [0, 2^FB] with (2m-1)^2 * S <= 2 * n^2 * 4^FB.
    function automatic logic [COMP_W-1:0] unit_comp(logic signed [33:0] n,
                                                    logic [127:0] s);
        logic [33:0]  mag;
        logic [127:0] rhs;
        logic [33:0]  m;
        logic [33:0]  c;
        logic [67:0]  t2;
        logic [199:0] lhs;
        mag = n < 0 ? -n : n;
        rhs = (128'(mag) * 128'(mag)) << (2 * FB + 1);
        m = '0;
        for (int b = FB; b >= 0; b--) begin
            c = m | (34'd1 << b);
            if (c > (34'd1 << FB)) continue;
            t2 = 68'(2 * c - 1) * 68'(2 * c - 1);
            lhs = 200'(t2) * 200'(s);
            if (lhs <= 200'(rhs)) m = c;
        end
        if (n < 0) m = -m;
        return m[COMP_W-1:0];
    endfunction

    function automatic unit_quat_t rotate_normalize(quat_t q);
        unit_quat_t r;
        logic signed [33:0] x, y, z, w;
        logic [127:0] s;
        x = 34'(signed'(q.x));
        y = 34'(signed'(q.y));
        z = 34'(signed'(q.z));
        w = 34'(signed'(q.w));
        s = 128'(x * x) + 128'(y * y) + 128'(z * z) + 128'(w * w);
        if (s == 0) begin
            r.data = {COMP_W'(1 << FB), {(3*COMP_W){1'b0}}};
            r.zero_norm = 1'b1;
        end else begin
            r.data = {unit_comp(-(x + y), s), unit_comp(y - x, s),
                      unit_comp(w - z, s), unit_comp(w + z, s)};
            r.zero_norm = 1'b0;
        end
        return r;
    endfunction

    task automatic send_quat(quat_t q);
        if (!calm && $urandom_range(3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= q;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_q.push_back(rotate_normalize(q));
    endtask

    task automatic send_idle;
        s_axis_tvalid <= 1'b0;
    endtask

    // Result side stall
    initial begin
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        unit_quat_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h/%b", $time, m_axis_tdata,
                         m_axis_tuser);
                failed = 1'b1;
            end else begin
                e = pending_q.pop_front();
                for (int k = 0; k < NUM_COMP; k++)
                    if (e.data[k*COMP_W +: COMP_W] !== m_axis_tdata[k*COMP_W +: COMP_W]) begin
                        $display("%0t: comp %0d expected %h actual %h", $time, k,
                                 e.data[k*COMP_W +: COMP_W],
                                 m_axis_tdata[k*COMP_W +: COMP_W]);
                        failed = 1'b1;
                    end
                if (e.zero_norm !== m_axis_tuser) begin
                    $display("%0t: zero_norm expected %b actual %b", $time,
                             e.zero_norm, m_axis_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return COMP_W'($urandom_range(0, 8)) - 4;
            3: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed;
        logic [COMP_W-1:0] v[6] = '{32'h0, 32'h8000_0000, 32'h7fff_ffff,
                                    32'hffff_ffff, 32'h1, 32'h4000_0000};
        send_quat('{w: 0, z: 0, y: 0, x: 0});
        for (int i = 0; i < 6; i++) begin
            send_quat('{w: v[i], z: v[i], y: v[i], x: v[i]});
            send_quat('{w: v[i], z: 0, y: 0, x: 0});
            send_quat('{w: 0, z: v[i], y: 0, x: 0});
        end
        send_quat('{w: 0, z: 0, y: 32'h8000_0000, x: 0});
        send_quat('{w: 0, z: 0, y: 0, x: 32'h7fff_ffff});
        send_quat('{w: 32'h8000_0000, z: 32'h7fff_ffff, y: 32'h8000_0000,
                    x: 32'h7fff_ffff});
        send_quat('{w: 32'h5555_5555, z: 32'haaaa_aaaa, y: 32'h3333_3333,
                    x: 32'hcccc_cccc});
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_quat('{w: rand_comp(), z: rand_comp(), y: rand_comp(),
                        x: rand_comp()});
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(850);
        calm = 1'b1;
        test_random(200);
        send_idle();
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (FRAC_BITS_DEF + 20) @(posedge aclk);
        if (!failed) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/etnqn_pkg.sv
rtl/core/enu_to_ned_quaternion_normalize_core.sv
sim/tb_enu_to_ned_quaternion_normalize_core.sv
